### src/atcur_pkg.sv
// ----------------------------------------------------------------------------
// atcur_pkg
// Shared types, constants and helpers of the associative tag directory with
// use-count replacement.
// ----------------------------------------------------------------------------
package atcur_pkg;

  // Field widths fixed by the interface.
  localparam int TAG_W     = 32;
  localparam int CNT_W     = 31;
  localparam int IDX_OUT_W = 5;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  // Command codes carried in the cmd field.
  localparam logic CMD_ACCESS = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH,
    S_CLEAR
  } state_t;

  // One directory line as stored in the line memory.
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [CNT_W-1:0] count;
  } line_entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the incoming tag
    logic scan_start;  // rewind the line address and the search results
    logic rd_en;       // read one line and advance the address
    logic commit;      // update the directory and load the result word
    logic clear;       // empty the directory and load a zero result word
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_addr;   // the read address points at the last line
    logic out_free;    // the output register can take a new word
  } stat_t;

  // Saturating increment of a counter.
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? CNT_MAX : v + CNT_ONE;
  endfunction

endpackage

### src/atcur_ctrl.sv
// ----------------------------------------------------------------------------
// atcur_ctrl
// Controller of the tag directory: sequences the line scan, the final update
// and the clear command, and holds off the input while a word is in work.
// ----------------------------------------------------------------------------
module atcur_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_cmd,
  output logic            in_stall,
  input  atcur_pkg::stat_t stat,
  output atcur_pkg::ctl_t  ctl
);
  import atcur_pkg::*;

  state_t state;
  state_t state_next;

  logic in_take;

  assign in_take = in_valid && (state == S_IDLE);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_take) begin
          state_next = (in_cmd == CMD_CLEAR) ? S_CLEAR : S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.last_addr) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_FINISH;
      end
      S_FINISH, S_CLEAR: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    ctl      = '0;
    in_stall = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall       = 1'b0;
        ctl.load       = in_take;
        ctl.scan_start = in_take;
      end
      S_SCAN: begin
        ctl.rd_en = 1'b1;
      end
      S_DRAIN: begin
        ctl = '0;
      end
      S_FINISH: begin
        ctl.commit = stat.out_free;
      end
      S_CLEAR: begin
        ctl.clear = stat.out_free;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

endmodule

### src/atcur_dp.sv
// ----------------------------------------------------------------------------
// atcur_dp
// Datapath of the tag directory: line memory, valid bits, the one-line-per-
// cycle search for match, free line and smallest use count, the totals and
// the output register.
// ----------------------------------------------------------------------------
module atcur_dp #(
  parameter int NUM_LINES = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  atcur_pkg::ctl_t                 ctl,
  output atcur_pkg::stat_t                stat,
  input  logic [atcur_pkg::TAG_W-1:0]     lookup_tag,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            was_hit,
  output logic [atcur_pkg::IDX_OUT_W-1:0] line_index,
  output logic [atcur_pkg::CNT_W-1:0]     hits_so_far,
  output logic [atcur_pkg::CNT_W-1:0]     misses_so_far
);
  import atcur_pkg::*;

  localparam int IDX_W = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_LINES - 1);

  // Directory storage.
  line_entry_t           mem [NUM_LINES];
  logic [NUM_LINES-1:0]  line_valid;

  // Scan pipeline.
  logic [TAG_W-1:0]      key;
  logic [IDX_W-1:0]      addr;
  logic                  rd_vld;
  logic [IDX_W-1:0]      rd_idx;
  logic                  rd_line_valid;
  line_entry_t           rd_data;

  // Search results.
  logic                  found;
  logic [IDX_W-1:0]      match_idx;
  logic [CNT_W-1:0]      match_cnt;
  logic                  free_found;
  logic [IDX_W-1:0]      free_idx;
  logic [IDX_W-1:0]      min_idx;
  logic [CNT_W-1:0]      min_cnt;

  // Totals.
  logic [CNT_W-1:0]      hit_total;
  logic [CNT_W-1:0]      miss_total;
  logic [CNT_W-1:0]      hit_total_next;
  logic [CNT_W-1:0]      miss_total_next;

  logic [IDX_W-1:0]      victim;
  line_entry_t           wr_entry;
  logic [IDX_W+IDX_OUT_W-1:0] victim_ext;
  logic                  out_free;

  assign out_free       = !out_valid || !out_stall;
  assign stat.out_free  = out_free;
  assign stat.last_addr = (addr == LAST_IDX);

  // Victim choice and the word written back to the chosen line.
  always_comb begin
    if (found) begin
      victim = match_idx;
    end else if (free_found) begin
      victim = free_idx;
    end else begin
      victim = min_idx;
    end
    wr_entry.tag   = key;
    wr_entry.count = found ? sat_inc(match_cnt) : CNT_ONE;
    hit_total_next  = found ? sat_inc(hit_total) : hit_total;
    miss_total_next = found ? miss_total : sat_inc(miss_total);
    victim_ext      = {{IDX_OUT_W{1'b0}}, victim};
  end

  // Line memory: one read per line during the scan, one write at the update.
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[addr];
    end
    if (ctl.commit) begin
      mem[victim] <= wr_entry;
    end
  end

  // Tag capture, read address and read pipeline.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      key <= lookup_tag;
    end
    if (ctl.scan_start) begin
      addr <= '0;
    end else if (ctl.rd_en) begin
      addr <= addr + IDX_W'(1);
    end
    rd_idx        <= addr;
    rd_line_valid <= line_valid[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= ctl.rd_en;
    end
  end

  // Search over the lines as they come out of the memory.
  always_ff @(posedge clk) begin
    if (rst || ctl.scan_start) begin
      found      <= 1'b0;
      free_found <= 1'b0;
    end else if (rd_vld) begin
      if (rd_line_valid && (rd_data.tag == key) && !found) begin
        found     <= 1'b1;
        match_idx <= rd_idx;
        match_cnt <= rd_data.count;
      end
      if (!rd_line_valid && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= rd_idx;
      end
      if ((rd_idx == '0) || (rd_data.count < min_cnt)) begin
        min_cnt <= rd_data.count;
        min_idx <= rd_idx;
      end
    end
  end

  // Valid bits and totals.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      line_valid <= '0;
      hit_total  <= '0;
      miss_total <= '0;
    end else if (ctl.commit) begin
      line_valid[victim] <= 1'b1;
      hit_total          <= hit_total_next;
      miss_total         <= miss_total_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.commit || ctl.clear) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      was_hit       <= 1'b0;
      line_index    <= '0;
      hits_so_far   <= '0;
      misses_so_far <= '0;
    end else if (ctl.commit) begin
      was_hit       <= found;
      line_index    <= victim_ext[IDX_OUT_W-1:0];
      hits_so_far   <= hit_total_next;
      misses_so_far <= miss_total_next;
    end
  end

`ifndef NO_ASSERTIONS
  // A result word is only loaded when the output register can take it.
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    (ctl.commit || ctl.clear) |-> out_free)
    else $error("result word loaded over a stalled word");

  // The line chosen at an update is valid afterwards.
  a_victim_valid: assert property (@(posedge clk) disable iff (rst)
    ctl.commit |=> line_valid[$past(victim)])
    else $error("updated line is not valid");

  // A clear empties the directory and both totals.
  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    ctl.clear |=> (line_valid == '0) && (hit_total == '0) && (miss_total == '0))
    else $error("clear left state behind");

  // A miss always leaves a nonzero miss total.
  a_miss_counted: assert property (@(posedge clk) disable iff (rst)
    (ctl.commit && !found) |=> (miss_total != '0))
    else $error("miss not counted");
`endif

endmodule

### src/assoc_tag_cache_use_count_replace_core.sv
// ----------------------------------------------------------------------------
// assoc_tag_cache_use_count_replace_core
// Tag directory of a fully associative cache with least-frequently-used
// replacement, hit and miss totals, and a clear command.
// ----------------------------------------------------------------------------
// Sequence: an access result word is presented after the line scan, the search
//   drain and the update; a clear loads a zero result word without a scan.
// Flow: one word at a time; the scan reads one line per cycle, and a stalled
//   result word holds the next update off, and with it the next input word.
// Reset: synchronous; all lines invalid, both totals zero, no result pending.
// ----------------------------------------------------------------------------
module assoc_tag_cache_use_count_replace_core #(
  parameter int NUM_LINES = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            cmd,
  input  logic [atcur_pkg::TAG_W-1:0]     lookup_tag,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            was_hit,
  output logic [atcur_pkg::IDX_OUT_W-1:0] line_index,
  output logic [atcur_pkg::CNT_W-1:0]     hits_so_far,
  output logic [atcur_pkg::CNT_W-1:0]     misses_so_far
);
  import atcur_pkg::*;

  ctl_t  ctl;
  stat_t stat;

  // Controller.
  atcur_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_cmd   (cmd),
    .in_stall (in_stall),
    .stat     (stat),
    .ctl      (ctl)
  );

  // Datapath.
  atcur_dp #(
    .NUM_LINES (NUM_LINES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .stat          (stat),
    .lookup_tag    (lookup_tag),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .was_hit       (was_hit),
    .line_index    (line_index),
    .hits_so_far   (hits_so_far),
    .misses_so_far (misses_so_far)
  );

endmodule
